// ===== src/smmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smmd_pkg
// Shared types, address map constants and the decode helper for the segmented
// memory map with sprite-table DMA.
// ----------------------------------------------------------------------------
package smmd_pkg;

    // Defaults for top-level parameters
    localparam int DMA_LENGTH_DEF  = 160;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Backing memory covers the whole 16-bit space
    localparam int MEM_WIDTH = 8;
    localparam int MEM_DEPTH = 65536;

    // Address map
    localparam logic [15:0] WORK1_END   = 16'hE000;
    localparam logic [15:0] SPRITE_BASE = 16'hFE00;
    localparam logic [15:0] SPRITE_END  = 16'hFEA0;
    localparam logic [15:0] IO_BASE     = 16'hFF00;
    localparam logic [15:0] DMA_ADDR    = 16'hFF46;
    localparam logic [7:0]  SPRITE_PAGE = 8'hFE;
    localparam logic [7:0]  IO_PAGE     = 8'hFF;
    localparam logic [7:0]  REG_DIV     = 8'h04;
    localparam logic [7:0]  REG_STAT    = 8'h41;
    localparam logic [7:0]  COINC_MASK  = 8'h04;
    localparam logic [7:0]  UNMAPPED_RD = 8'hFF;

    // Bus action codes as seen on the input channel
    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_FLAG  = 2'd3
    } t_action;

    // Classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_READ   = 3'd0,
        OP_RD_UNM = 3'd1,
        OP_WRITE  = 3'd2,
        OP_WR_UNM = 3'd3,
        OP_DMA    = 3'd4,
        OP_TICK   = 3'd5,
        OP_FLAG   = 3'd6
    } t_op;

    typedef struct packed {
        t_action     action;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        flag_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       unmapped;
        logic       dma_started;
    } t_result;

    typedef struct packed {
        t_op         op;
        logic [15:0] address;
        logic [7:0]  data;
        logic        flag_value;
    } t_cmd;

    // True when the address falls in any segment
    function automatic logic is_mapped(input logic [15:0] a);
        return (a < WORK1_END) || ((a >= SPRITE_BASE) && (a < SPRITE_END)) || (a >= IO_BASE);
    endfunction

endpackage

// ===== src/smmd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smmd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/smmd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smmd_front
// Accepts bus transactions, classifies them against the address map and
// queues the resulting commands for the execution side.
// ----------------------------------------------------------------------------
module smmd_front import smmd_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_hold,
    input  logic     i_in_valid,
    input  t_in_item i_in_data,
    output logic     o_in_ready,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_q [QUEUE_DEPTH];
    logic [IW-1:0] r_wr, n_wr;
    logic [IW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    t_cmd          cls_cmd;
    logic          push;

    // Classify the incoming transaction
    always_comb begin
        cls_cmd.address    = i_in_data.address;
        cls_cmd.data       = i_in_data.write_data;
        cls_cmd.flag_value = i_in_data.flag_value;
        unique case (i_in_data.action)
            ACT_READ: begin
                cls_cmd.op = is_mapped(i_in_data.address) ? OP_READ : OP_RD_UNM;
            end
            ACT_WRITE: begin
                if (i_in_data.address == DMA_ADDR) begin
                    cls_cmd.op = OP_DMA;
                end else if (is_mapped(i_in_data.address)) begin
                    cls_cmd.op = OP_WRITE;
                end else begin
                    cls_cmd.op = OP_WR_UNM;
                end
            end
            ACT_TICK: begin
                cls_cmd.op = OP_TICK;
            end
            default: begin
                cls_cmd.op = OP_FLAG;
            end
        endcase
    end

    assign o_in_ready  = !i_hold && (r_count != CW'(QUEUE_DEPTH));
    assign push        = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd];

    // Advance pointers and occupancy
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (push) begin
            n_wr = (r_wr == IW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_cmd_pop) begin
            n_rd = (r_rd == IW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (push && !i_cmd_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_cmd_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Store the classified command
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cls_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("command queue over capacity");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> (r_count != '0))
        else $error("pop from empty command queue");

    a_hold_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_hold |-> !push)
        else $error("transaction taken while held");

endmodule

// ===== src/smmd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smmd_back
// Executes queued commands against the backing memory: plain reads and
// writes, divider and status read-modify-write, and the sprite-table DMA.
// Also runs the clearing pass after reset and holds the result register.
// ----------------------------------------------------------------------------
module smmd_back import smmd_pkg::*; #(
    parameter int DMA_LENGTH = DMA_LENGTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    o_clearing,
    output logic    o_out_valid,
    output t_result o_out_data,
    input  logic    i_out_ready
);

    localparam int CW = $clog2(DMA_LENGTH + 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_RMW   = 5'b01000,
        S_DMA   = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    logic [15:0]   r_clr_addr, n_clr_addr;
    t_cmd          r_cmd, n_cmd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_wr_valid, n_wr_valid;
    logic [CW-1:0] r_wr_idx, n_wr_idx;
    logic          r_wr_unm, n_wr_unm;
    logic          r_out_valid, n_out_valid;
    t_result       r_out, n_res;
    logic          load;

    logic          ram_we;
    logic [15:0]   ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [15:0]   ram_raddr;
    logic [7:0]    ram_rdata;
    logic [15:0]   dma_src;
    logic          dma_rd;

    smmd_ram #(
        .WIDTH (MEM_WIDTH),
        .DEPTH (MEM_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Take a command only when the result slot is free or draining
    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_clearing = (r_state == S_CLEAR);
    assign dma_src    = {r_cmd.data, 8'(r_cnt)};
    assign dma_rd     = (r_cnt != CW'(DMA_LENGTH));

    // Sequence memory operations
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_cmd      = r_cmd;
        n_cnt      = r_cnt;
        n_wr_valid = r_wr_valid;
        n_wr_idx   = r_wr_idx;
        n_wr_unm   = r_wr_unm;
        ram_we     = 1'b0;
        ram_waddr  = r_clr_addr;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = i_cmd.address;
        load       = 1'b0;
        n_res      = '0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == 16'hFFFF) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_cmd_pop) begin
                    n_cmd = i_cmd;
                    unique case (i_cmd.op)
                        OP_READ: begin
                            ram_re  = 1'b1;
                            n_state = S_READ;
                        end
                        OP_RD_UNM: begin
                            load            = 1'b1;
                            n_res.read_data = UNMAPPED_RD;
                            n_res.unmapped  = 1'b1;
                        end
                        OP_WRITE: begin
                            ram_we    = 1'b1;
                            ram_waddr = i_cmd.address;
                            ram_wdata = i_cmd.data;
                            load      = 1'b1;
                        end
                        OP_WR_UNM: begin
                            load           = 1'b1;
                            n_res.unmapped = 1'b1;
                        end
                        OP_DMA: begin
                            n_cnt      = '0;
                            n_wr_valid = 1'b0;
                            n_state    = S_DMA;
                        end
                        OP_TICK: begin
                            ram_re    = 1'b1;
                            ram_raddr = {IO_PAGE, REG_DIV};
                            n_state   = S_RMW;
                        end
                        OP_FLAG: begin
                            ram_re    = 1'b1;
                            ram_raddr = {IO_PAGE, REG_STAT};
                            n_state   = S_RMW;
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                load            = 1'b1;
                n_res.read_data = ram_rdata;
                n_state         = S_IDLE;
            end
            S_RMW: begin
                ram_we = 1'b1;
                if (r_cmd.op == OP_TICK) begin
                    ram_waddr = {IO_PAGE, REG_DIV};
                    ram_wdata = ram_rdata + 8'd1;
                end else begin
                    ram_waddr = {IO_PAGE, REG_STAT};
                    ram_wdata = (ram_rdata & ~COINC_MASK) |
                                (r_cmd.flag_value ? COINC_MASK : 8'h00);
                end
                load    = 1'b1;
                n_state = S_IDLE;
            end
            S_DMA: begin
                // Read byte i while writing byte i-1 into the sprite table
                if (dma_rd) begin
                    ram_re    = 1'b1;
                    ram_raddr = dma_src;
                    n_cnt     = r_cnt + 1'b1;
                end
                n_wr_valid = dma_rd;
                n_wr_idx   = r_cnt;
                n_wr_unm   = !is_mapped(dma_src);
                if (r_wr_valid) begin
                    ram_we    = 1'b1;
                    ram_waddr = {SPRITE_PAGE, 8'(r_wr_idx)};
                    ram_wdata = r_wr_unm ? UNMAPPED_RD : ram_rdata;
                end
                if (!dma_rd) begin
                    load              = 1'b1;
                    n_res.dma_started = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = load || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_wr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_wr_valid  <= n_wr_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_cnt    <= n_cnt;
        r_wr_idx <= n_wr_idx;
        r_wr_unm <= n_wr_unm;
        if (load) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE))
        else $error("command taken outside idle");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    a_dma_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && (r_state == S_DMA)) |->
            ((ram_waddr[15:8] == SPRITE_PAGE) && (ram_waddr[7:0] < 8'(DMA_LENGTH))))
        else $error("DMA write outside sprite table");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CLEAR) && (r_clr_addr == 16'hFFFF)) |=> (r_state == S_IDLE))
        else $error("clearing pass did not finish");

endmodule

// ===== src/segmented_memory_map_with_oam_dma_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_memory_map_with_oam_dma_core
// 8-bit bus over a 16-bit address space with segment decode, unmapped
// detection, divider and status updates, and a sprite-table DMA copy.
// ----------------------------------------------------------------------------
// Flow: each transaction is queued by the front, taken by the back in idle and
//   its result registered. Writes and unmapped accesses go at one per cycle while
//   results drain; reads, ticks and flag updates add a registered memory read, and
//   a DMA copy runs to its end, before the back takes another command.
// Reset: after i_rst_n the backing memory is zeroed one byte per cycle; no
//   transaction is accepted until that pass is done.
module segmented_memory_map_with_oam_dma_core import smmd_pkg::*; #(
    parameter int DMA_LENGTH  = DMA_LENGTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_data,
    output logic     o_in_ready,
    output logic     o_out_valid,
    output t_result  o_out_data,
    input  logic     i_out_ready
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;
    logic clearing;

    // Accept and classify
    smmd_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (clearing),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Execute against memory
    smmd_back #(
        .DMA_LENGTH (DMA_LENGTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

endmodule
